// ----- rtl/core/mcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcfd_pkg
// Types and constants shared by the motor command frame decoder.
// ----------------------------------------------------------------------------
package mcfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DUTY_W = 16;

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_FULL    = 8'hFF;

  localparam logic [BYTE_W-1:0] ESC_FORCE_LOW  = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_FORCE_HIGH = 8'h02;
  localparam logic [BYTE_W-1:0] ESC_FORCE_BOTH = 8'h03;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_DIR  = 5'b00010,
    PH_HIGH = 5'b00100,
    PH_LOW  = 5'b01000,
    PH_ESC  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              direction;
    logic [DUTY_W-1:0] duty;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_slot_t;

endpackage

// ----- rtl/core/mcfd_if.sv -----
// ----------------------------------------------------------------------------
// mcfd_if
// Valid/ready channels: received bytes, decoded commands, marker writes.
// ----------------------------------------------------------------------------
interface mcfd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [mcfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcfd_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       direction;
  logic [mcfd_pkg::DUTY_W-1:0] duty;

  modport source (output valid, output direction, output duty, input ready);
  modport sink   (input valid, input direction, input duty, output ready);
endinterface

interface mcfd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mcfd_pkg::BYTE_W-1:0] start_marker;

  modport source (output valid, output start_marker, input ready);
  modport sink   (input valid, input start_marker, output ready);
endinterface

// ----- rtl/core/motor_command_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// motor_command_frame_decoder
// Start-marker framed serial command parser: direction and 16-bit duty.
// ----------------------------------------------------------------------------
//  channel  dir  payload                        note
//  rx       in   rx_byte[7:0]                   one byte per transaction
//  cmd      out  direction, duty[15:0]          one per complete frame
//  cfg      in   start_marker[7:0]              always ready
//
//  One byte per cycle sustained unless cmd stalls; input register then result
//  register, so a command is loaded once its escape byte leaves the input register.
//  rst (synchronous) returns to hunting, marker 0xFF, held fields zero.
//  A stalled cmd only holds rx when a second command is due to load.
// ----------------------------------------------------------------------------
module motor_command_frame_decoder (
  input  logic       clk,
  input  logic       rst,
  mcfd_rx_if.sink    rx,
  mcfd_cmd_if.source cmd,
  mcfd_cfg_if.sink   cfg
);

  logic [mcfd_pkg::BYTE_W-1:0] marker;
  mcfd_pkg::byte_slot_t        slot;
  mcfd_pkg::cmd_t              frame_cmd;
  logic                        emit;
  logic                        can_load;
  logic                        step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= mcfd_pkg::MARKER_RESET;
    end else if (cfg.valid && cfg.ready) begin
      marker <= cfg.start_marker;
    end
  end

  assign step = slot.valid && (!emit || can_load);

  mcfd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .consume (step),
    .slot    (slot)
  );

  mcfd_frame_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .data   (slot.data),
    .marker (marker),
    .emit   (emit),
    .cmd    (frame_cmd)
  );

  mcfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && emit),
    .cmd_in   (frame_cmd),
    .can_load (can_load),
    .cmd      (cmd)
  );

endmodule

// ----- rtl/core/mcfd_in_stage.sv -----
// ----------------------------------------------------------------------------
// mcfd_in_stage
// Input register for received bytes; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module mcfd_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  mcfd_rx_if.sink              rx,
  input  logic                 consume,
  output mcfd_pkg::byte_slot_t slot
);

  logic                        held_valid;
  logic [mcfd_pkg::BYTE_W-1:0] held_byte;

  assign rx.ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.ready) begin
      held_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      held_byte <= rx.rx_byte;
    end
  end

  assign slot.valid = held_valid;
  assign slot.data  = held_byte;

endmodule

// ----- rtl/core/mcfd_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// mcfd_frame_fsm
// Frame phase machine, held fields and escape decoding.
// ----------------------------------------------------------------------------
module mcfd_frame_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [mcfd_pkg::BYTE_W-1:0] data,
  input  logic [mcfd_pkg::BYTE_W-1:0] marker,
  output logic                        emit,
  output mcfd_pkg::cmd_t              cmd
);

  mcfd_pkg::phase_t            phase;
  mcfd_pkg::phase_t            phase_next;
  logic                        dir_held;
  logic [mcfd_pkg::BYTE_W-1:0] high_held;
  logic [mcfd_pkg::BYTE_W-1:0] low_held;
  logic [mcfd_pkg::BYTE_W-1:0] hi;
  logic [mcfd_pkg::BYTE_W-1:0] lo;

  always_comb begin
    unique case (phase)
      mcfd_pkg::PH_DIR:  phase_next = mcfd_pkg::PH_HIGH;
      mcfd_pkg::PH_HIGH: phase_next = mcfd_pkg::PH_LOW;
      mcfd_pkg::PH_LOW:  phase_next = mcfd_pkg::PH_ESC;
      mcfd_pkg::PH_ESC:  phase_next = mcfd_pkg::PH_HUNT;
      default: begin
        phase_next = (data == marker) ? mcfd_pkg::PH_DIR : mcfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mcfd_pkg::PH_HUNT;
      dir_held  <= 1'b0;
      high_held <= '0;
      low_held  <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (phase == mcfd_pkg::PH_DIR) begin
        dir_held <= (data != '0);
      end
      if (phase == mcfd_pkg::PH_HIGH) begin
        high_held <= data;
      end
      if (phase == mcfd_pkg::PH_LOW) begin
        low_held <= data;
      end
    end
  end

  always_comb begin
    hi = high_held;
    lo = low_held;
    unique case (data)
      mcfd_pkg::ESC_FORCE_BOTH: begin
        hi = mcfd_pkg::BYTE_FULL;
        lo = mcfd_pkg::BYTE_FULL;
      end
      mcfd_pkg::ESC_FORCE_HIGH: hi = mcfd_pkg::BYTE_FULL;
      mcfd_pkg::ESC_FORCE_LOW:  lo = mcfd_pkg::BYTE_FULL;
      default: ;
    endcase
  end

  assign emit          = (phase == mcfd_pkg::PH_ESC);
  assign cmd.direction = dir_held;
  assign cmd.duty      = {hi, lo};

endmodule

// ----- rtl/core/mcfd_out_stage.sv -----
// ----------------------------------------------------------------------------
// mcfd_out_stage
// Result register driving the command channel.
// ----------------------------------------------------------------------------
module mcfd_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  mcfd_pkg::cmd_t cmd_in,
  output logic           can_load,
  mcfd_cmd_if.source     cmd
);

  logic           full;
  mcfd_pkg::cmd_t held;

  assign can_load = !full || cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (can_load) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= cmd_in;
    end
  end

  assign cmd.valid     = full;
  assign cmd.direction = held.direction;
  assign cmd.duty      = held.duty;

endmodule

// ----- test/motor_command_frame_decoder_test.sv -----
// ----------------------------------------------------------------------------
// motor_command_frame_decoder_test
// Streams received bytes into the frame decoder through a clocked driver with
// random gaps. A frame predictor works out each command from the bytes as they
// are accepted. A clocked monitor with random back-pressure checks every
// command transaction against the oldest prediction. The start marker is
// rewritten between phases once the decoder has drained, including once in
// the middle of a frame. Directed frames cover zero and full-scale fields,
// every escape code and the marker taken as data. Random phases follow.
// ----------------------------------------------------------------------------
module motor_command_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTE_W      = mcfd_pkg::BYTE_W;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst;

  mcfd_rx_if  rx ();
  mcfd_cmd_if cmd ();
  mcfd_cfg_if cfg ();

  motor_command_frame_decoder dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .cmd (cmd),
    .cfg (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // frame predictor state
  logic [BYTE_W-1:0] marker_now = mcfd_pkg::MARKER_RESET;
  mcfd_pkg::phase_t  phase_now  = mcfd_pkg::PH_HUNT;
  logic              held_dir   = 1'b0;
  logic [BYTE_W-1:0] held_high  = '0;
  logic [BYTE_W-1:0] held_low   = '0;

  logic [BYTE_W-1:0] rx_backlog[$];
  mcfd_pkg::cmd_t    due_cmds[$];

  int   bad_count   = 0;
  int   bytes_taken = 0;
  int   cmds_seen   = 0;
  int   cycle_count = 0;
  logic steady      = 1'b0;
  logic hold_off    = 1'b0;

  task automatic note_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    mcfd_pkg::cmd_t c;
    case (phase_now)
      mcfd_pkg::PH_DIR: begin
        held_dir  = (b != '0);
        phase_now = mcfd_pkg::PH_HIGH;
      end
      mcfd_pkg::PH_HIGH: begin
        held_high = b;
        phase_now = mcfd_pkg::PH_LOW;
      end
      mcfd_pkg::PH_LOW: begin
        held_low  = b;
        phase_now = mcfd_pkg::PH_ESC;
      end
      mcfd_pkg::PH_ESC: begin
        c.direction = held_dir;
        c.duty      = {held_high, held_low};
        if (b == mcfd_pkg::ESC_FORCE_BOTH) begin
          c.duty = {mcfd_pkg::BYTE_FULL, mcfd_pkg::BYTE_FULL};
        end else if (b == mcfd_pkg::ESC_FORCE_HIGH) begin
          c.duty[15:8] = mcfd_pkg::BYTE_FULL;
        end else if (b == mcfd_pkg::ESC_FORCE_LOW) begin
          c.duty[7:0] = mcfd_pkg::BYTE_FULL;
        end
        due_cmds.push_back(c);
        phase_now = mcfd_pkg::PH_HUNT;
      end
      default: begin
        phase_now = (b == marker_now) ? mcfd_pkg::PH_DIR : mcfd_pkg::PH_HUNT;
      end
    endcase
  endtask

  // byte driver and predictor feed
  always @(posedge clk) begin : drive_rx
    int gap_left;
    if (rst) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= '0;
      gap_left = 0;
    end else begin
      if (rx.valid && rx.ready) begin
        decode_byte(rx.rx_byte);
        bytes_taken++;
      end
      if (cfg.valid && cfg.ready) begin
        marker_now = cfg.start_marker;
      end
      if (!(rx.valid && !rx.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          rx.valid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          rx.valid   <= 1'b1;
          rx.rx_byte <= rx_backlog.pop_front();
          gap_left = next_gap();
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // command monitor with random back-pressure
  always @(posedge clk) begin : watch_cmd
    int             stall_left;
    mcfd_pkg::cmd_t want;
    if (rst) begin
      cmd.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        cmds_seen++;
        if (due_cmds.size() == 0) begin
          note_bad($sformatf("cmd %0d: unexpected transaction dir %0b duty %04h",
                             cmds_seen, cmd.direction, cmd.duty));
        end else begin
          want = due_cmds.pop_front();
          if (cmd.direction !== want.direction || cmd.duty !== want.duty) begin
            note_bad($sformatf("cmd %0d: expected dir %0b duty %04h, got dir %0b duty %04h",
                               cmds_seen, want.direction, want.duty,
                               cmd.direction, cmd.duty));
          end
        end
      end
      if (hold_off) begin
        cmd.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        cmd.ready <= 1'b0;
      end else begin
        cmd.ready <= 1'b1;
        stall_left = next_gap();
      end
    end
  end

  // long receiver hold-off while bytes keep coming
  initial begin
    wait (bytes_taken >= 100);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic settle();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || rx.valid || due_cmds.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_marker(input logic [BYTE_W-1:0] m);
    @(posedge clk);
    cfg.valid        <= 1'b1;
    cfg.start_marker <= m;
    do @(posedge clk);
    while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] field_byte();
    if ($urandom_range(0, 9) == 0) return marker_now;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // mostly well-formed frames, some noise and truncated frames
  task automatic queue_frames(input int target);
    int placed;
    int r;
    int cut;
    placed = 0;
    while (placed < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        rx_backlog.push_back(marker_now);
        rx_backlog.push_back(($urandom_range(0, 3) == 0) ? '0 : field_byte());
        rx_backlog.push_back(field_byte());
        rx_backlog.push_back(field_byte());
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rx_backlog.push_back(BYTE_W'($urandom_range(1, 3)));
        end else if (r < 75) begin
          rx_backlog.push_back('0);
        end else begin
          rx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        placed += 5;
      end else if (r < 90) begin
        rx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
        placed += 1;
      end else begin
        cut = $urandom_range(1, 3);
        rx_backlog.push_back(marker_now);
        repeat (cut) rx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
        placed += cut + 1;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    rx.valid         = 1'b0;
    rx.rx_byte       = '0;
    cfg.valid        = 1'b0;
    cfg.start_marker = '0;
    cmd.ready        = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames at the reset marker
    rx_backlog = '{8'h55,
                   8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'hFF, 8'h01, 8'h12, 8'h34, mcfd_pkg::ESC_FORCE_LOW,
                   8'hFF, 8'h80, 8'hFF, 8'hAB, mcfd_pkg::ESC_FORCE_HIGH,
                   8'hFF, 8'hFF, 8'h00, 8'h7F, mcfd_pkg::ESC_FORCE_BOTH,
                   8'hFF, 8'h01, 8'h5A, 8'hA5, 8'hFE,
                   8'hFF, 8'h02};
    settle();

    // marker changed with a frame open; the frame completes on the old framing
    write_marker(8'h00);
    rx_backlog.push_back(8'hC3);
    rx_backlog.push_back(8'h3C);
    rx_backlog.push_back(8'h05);
    queue_frames(230);
    settle();

    steady = 1'b1;
    write_marker(8'hFF);
    queue_frames(200);
    settle();
    steady = 1'b0;

    write_marker(BYTE_W'($urandom_range(1, 254)));
    queue_frames(230);
    settle();

    write_marker(8'h80);
    queue_frames(230);
    settle();

    write_marker(BYTE_W'($urandom_range(0, 255)));
    queue_frames(230);
    settle();

    repeat (10) @(posedge clk);
    if (due_cmds.size() != 0) begin
      note_bad($sformatf("%0d command(s) never arrived", due_cmds.size()));
    end
    if (bad_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
